[hdl/lfs_pkg.sv]
// lfs_pkg: fixed-point constants, register indexes, mode codes and
// rounding/saturation helpers for the ladder filter step block.
// No dependencies.
`default_nettype none

package lfs_pkg;

  localparam int NSTAGE = 5;

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = -24'sh800000;

  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [23:0] B0_Q16       = 24'd50412;
  localparam logic [23:0] GAIN_OUT_Q16 = 24'd78643;

  // configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_IN_DRV  = 3'd1;
  localparam logic [2:0] REG_IN_GAIN = 3'd2;
  localparam logic [2:0] REG_FB_DRV  = 3'd3;
  localparam logic [2:0] REG_FB_GAIN = 3'd4;

  // filter modes
  localparam logic [2:0] MODE_LPF12 = 3'd0;
  localparam logic [2:0] MODE_HPF12 = 3'd1;
  localparam logic [2:0] MODE_BPF12 = 3'd2;
  localparam logic [2:0] MODE_LPF24 = 3'd3;
  localparam logic [2:0] MODE_HPF24 = 3'd4;
  localparam logic [2:0] MODE_BPF24 = 3'd5;

  // add half, then floor shift
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] one;
    one = 64'sd1;
    return (v + (one <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'(S_MAX)) begin
      r = S_MAX;
    end else if (v < 64'(S_MIN)) begin
      r = S_MIN;
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

  // integer mixing weight of stage j in a mode
  function automatic logic signed [3:0] mode_weight(input logic [2:0] mode,
                                                    input logic [2:0] j);
    logic signed [3:0] w;
    w = 4'sd0;
    case (mode)
      MODE_LPF12: begin
        if (j == 3'd2) w = 4'sd1;
      end
      MODE_HPF12: begin
        case (j)
          3'd0: w = 4'sd1;
          3'd1: w = -4'sd2;
          3'd2: w = 4'sd1;
          default: w = 4'sd0;
        endcase
      end
      MODE_BPF12: begin
        case (j)
          3'd1: w = 4'sd1;
          3'd2: w = -4'sd1;
          default: w = 4'sd0;
        endcase
      end
      MODE_LPF24: begin
        if (j == 3'd4) w = 4'sd1;
      end
      MODE_HPF24: begin
        case (j)
          3'd0: w = 4'sd1;
          3'd1: w = -4'sd4;
          3'd2: w = 4'sd6;
          3'd3: w = -4'sd4;
          3'd4: w = 4'sd1;
          default: w = 4'sd0;
        endcase
      end
      MODE_BPF24: begin
        case (j)
          3'd2: w = 4'sd1;
          3'd3: w = -4'sd2;
          3'd4: w = 4'sd1;
          default: w = 4'sd0;
        endcase
      end
      default: w = 4'sd0;
    endcase
    return w;
  endfunction

  // feedback compensation of half the input in low- and band-pass modes
  function automatic logic comp_half(input logic [2:0] mode);
    return (mode != MODE_HPF12) && (mode != MODE_HPF24);
  endfunction

endpackage

`default_nettype wire

[hdl/ladder_filter_step_top.sv]
// ladder_filter_step_top: four-pole transistor-ladder filter step, one
// shared multiplier under a step sequencer. Depends on lfs_pkg.
`default_nettype none

// Four-pole ladder filter for up to CHANNELS audio channels, Q3.20 samples.
// Each input transaction carries one sample, its channel, the cutoff
// coefficient and the resonance; one output transaction with the filtered
// sample follows. All arithmetic goes through a single registered 32x24
// signed multiplier driven by a step sequencer: coefficient setup, two
// drive/tanh/gain passes, the resonance mix, four one-pole stages and the
// mode mix with state writeback. A hand-off state, which waits while the
// output register is held, then moves the result into it and raises
// out_valid; the block then returns to idle, where the next transaction is
// taken, so no new sample is taken before the last is through. in_stall is
// high while an item is in flight; a finished result waits in the output
// register and the next input is taken meanwhile. The tanh curve is a
// constant table of SAT_TABLE_ENTRIES+1 points built at elaboration. Ladder
// state lives in a small memory; a mode change clears it at once through
// one valid bit per channel. Configuration is always ready and is meant to
// be written only while the block is idle.
module ladder_filter_step_top #(
  parameter int CHANNELS          = 2,
  parameter int SAT_TABLE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] in_sample_in,
  input  wire logic               in_channel,
  input  wire logic [16:0]        in_cutoff_coef,
  input  wire logic [16:0]        in_resonance_level,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_sample_out,
  output logic                    out_channel_out,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);

  localparam int ROWS = CHANNELS * lfs_pkg::NSTAGE;
  localparam int AW   = $clog2(ROWS);
  localparam int IW   = $clog2(SAT_TABLE_ENTRIES + 1);

  // table step h = 8 / entries in Q0.30, rounded
  localparam logic signed [63:0] TANH_STEP =
    ((64'sd8 <<< 30) + 64'(SAT_TABLE_ENTRIES / 2)) / 64'(SAT_TABLE_ENTRIES);

  typedef logic [30:0] tab_t [0:SAT_TABLE_ENTRIES];

  // restoring division for table construction
  function automatic logic [63:0] udiv_const(input logic [63:0] a,
                                             input logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh table in Q0.30: series for the first step, then the addition formula
  function automatic tab_t build_tanh();
    tab_t tab;
    logic signed [63:0] h, h2, p, t, den, num;
    h  = TANH_STEP;
    h2 = lfs_pkg::rnd_shift(h * h, 30);
    p  = h;
    t  = h;
    p  = lfs_pkg::rnd_shift(p * h2, 30);
    t  = t - p / 3;
    p  = lfs_pkg::rnd_shift(p * h2, 30);
    t  = t + (p * 2) / 15;
    p  = lfs_pkg::rnd_shift(p * h2, 30);
    t  = t - (p * 17) / 315;
    p  = lfs_pkg::rnd_shift(p * h2, 30);
    t  = t + (p * 62) / 2835;
    tab[0] = 31'd0;
    for (int k = 0; k < SAT_TABLE_ENTRIES; k++) begin
      den = (64'sd1 <<< 30) + lfs_pkg::rnd_shift($signed(64'(tab[k])) * t, 30);
      num = ($signed(64'(tab[k])) + t) <<< 30;
      tab[k + 1] = 31'(udiv_const($unsigned(num + (den >>> 1)), $unsigned(den)));
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tanh();

  // sequencer steps
  localparam logic [4:0] SP_COEF  = 5'd0;
  localparam logic [4:0] SP_BCOEF = 5'd1;
  localparam logic [4:0] SP_DRV   = 5'd2;
  localparam logic [4:0] SP_ARG   = 5'd3;
  localparam logic [4:0] SP_POS   = 5'd4;
  localparam logic [4:0] SP_IDX   = 5'd5;
  localparam logic [4:0] SP_LUT   = 5'd6;
  localparam logic [4:0] SP_INTP  = 5'd7;
  localparam logic [4:0] SP_TNH   = 5'd8;
  localparam logic [4:0] SP_GAIN  = 5'd9;
  localparam logic [4:0] SP_DSG   = 5'd10;
  localparam logic [4:0] SP_FBD   = 5'd11;
  localparam logic [4:0] SP_V0    = 5'd12;
  localparam logic [4:0] SP_MA    = 5'd13;
  localparam logic [4:0] SP_MB    = 5'd14;
  localparam logic [4:0] SP_MC    = 5'd15;
  localparam logic [4:0] SP_ACC   = 5'd16;
  localparam logic [4:0] SP_MIX   = 5'd17;
  localparam logic [4:0] SP_MIXE  = 5'd18;
  localparam logic [4:0] SP_GOUT  = 5'd19;
  localparam logic [4:0] SP_FIN   = 5'd20;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r;
  logic [4:0] step_r;
  logic       pass_r;     // 0: input sample, 1: fed-back last stage
  logic [2:0] cnt_r;      // stage index, then mix index

  // configuration registers
  logic [2:0]  mode_r;
  logic [15:0] in_drv_r, fb_drv_r;
  logic [16:0] in_gain_r, fb_gain_r;

  // transaction registers
  logic signed [23:0] x_r;
  logic               ch_in_r, ch_r;
  logic [16:0]        a1_r, resl_r, b0_r, b1_r;

  // datapath registers
  logic signed [55:0] prod_r;
  logic signed [47:0] acc_r;
  logic signed [23:0] arg_r, dx_r, fb_r;
  logic [IW-1:0]      idx_r;
  logic [22:0]        frac_r;
  logic               ovf_r, neg_r;
  logic [30:0]        lo_r, hi_r;
  logic signed [31:0] tanh_r;
  logic signed [23:0] v_r [0:lfs_pkg::NSTAGE-1];
  logic signed [23:0] res_r;

  // output register
  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic               out_ch_r;

  // ladder state memory and per-channel valid bits
  logic signed [23:0] mem [0:ROWS-1];
  logic signed [23:0] mem_q_r;
  logic [CHANNELS-1:0] row_valid_r;

  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic               rd_en, wr_en;
  logic [2:0]         rd_sel;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               row_valid;
  logic [16:0]        g;
  logic signed [24:0] arg_x, mag;
  logic signed [24:0] dxc;
  logic signed [25:0] fb_diff;
  logic signed [47:0] stage_sum;
  logic signed [31:0] tanh_mag;
  logic signed [23:0] dsg_val;
  logic               in_acc;
  logic               cfg_acc;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_channel_out = out_ch_r;

  assign g         = lfs_pkg::ONE_Q16 - a1_r;
  assign arg_x     = 25'(arg_r);
  assign mag       = arg_x[24] ? -arg_x : arg_x;
  assign dxc       = lfs_pkg::comp_half(mode_r) ? ((25'(dx_r) + 25'sd1) >>> 1) : 25'sd0;
  assign fb_diff   = 26'(fb_r) - 26'(dxc);
  assign stage_sum = acc_r + 48'(prod_r);
  assign tanh_mag  = $signed({1'b0, lo_r}) + $signed(prod_r[54:23]);
  assign dsg_val   = lfs_pkg::sat24(lfs_pkg::rnd_shift(64'(prod_r), 26));
  assign row_valid = |(row_valid_r & (CHANNELS'(1) << ch_r));

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 24'sd0;
    case (step_r)
      SP_COEF: begin
        mul_a = $signed({15'd0, g});
        mul_b = $signed(lfs_pkg::B0_Q16);
      end
      SP_DRV: begin
        mul_a = pass_r ? 32'(mem_q_r) : 32'(x_r);
        mul_b = $signed({8'd0, pass_r ? fb_drv_r : in_drv_r});
      end
      SP_POS: begin
        mul_a = 32'(mag);
        mul_b = 24'(SAT_TABLE_ENTRIES);
      end
      SP_INTP: begin
        mul_a = $signed({1'b0, hi_r - lo_r});
        mul_b = $signed({1'b0, frac_r});
      end
      SP_GAIN: begin
        mul_a = tanh_r;
        mul_b = $signed({7'd0, pass_r ? fb_gain_r : in_gain_r});
      end
      SP_FBD: begin
        mul_a = 32'(fb_diff);
        mul_b = $signed({7'd0, resl_r});
      end
      SP_MA: begin
        mul_a = 32'(mem_q_r);
        mul_b = $signed({7'd0, b1_r});
      end
      SP_MB: begin
        mul_a = 32'(mem_q_r);
        mul_b = $signed({7'd0, a1_r});
      end
      SP_MC: begin
        mul_a = 32'(v_r[cnt_r - 3'd1]);
        mul_b = $signed({7'd0, b0_r});
      end
      SP_MIX: begin
        mul_a = 32'(v_r[cnt_r]);
        mul_b = 24'(lfs_pkg::mode_weight(mode_r, cnt_r));
      end
      SP_GOUT: begin
        mul_a = acc_r[31:0];
        mul_b = $signed(lfs_pkg::GAIN_OUT_Q16);
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 24'sd0;
      end
    endcase
  end

  // state memory read/write select
  always_comb begin
    rd_en  = 1'b0;
    rd_sel = 3'd0;
    wr_en  = 1'b0;
    if (state_r == ST_RUN) begin
      case (step_r)
        SP_COEF: begin
          rd_en  = 1'b1;
          rd_sel = 3'd4;     // last stage for the feedback pass
        end
        SP_V0: begin
          rd_en  = 1'b1;
          rd_sel = 3'd0;
        end
        SP_MA, SP_ACC: begin
          rd_en  = 1'b1;
          rd_sel = cnt_r;
        end
        SP_MIX: begin
          wr_en = 1'b1;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
  end

  assign rd_addr = AW'(ch_r) * AW'(lfs_pkg::NSTAGE) + AW'(rd_sel);
  assign wr_addr = AW'(ch_r) * AW'(lfs_pkg::NSTAGE) + AW'(cnt_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= v_r[cnt_r];
    end
    if (rd_en) begin
      mem_q_r <= row_valid ? mem[rd_addr] : 24'sd0;
    end
  end

  // configuration registers and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lfs_pkg::MODE_LPF12;
      in_drv_r    <= 16'd4915;
      in_gain_r   <= 17'd50286;
      fb_drv_r    <= 16'd4129;
      fb_gain_r   <= 17'd64742;
      row_valid_r <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          lfs_pkg::REG_MODE: begin
            // codes above bpf24 are ignored; a new mode clears the ladders
            if (cfg_data[2:0] <= lfs_pkg::MODE_BPF24 && cfg_data[2:0] != mode_r) begin
              mode_r      <= cfg_data[2:0];
              row_valid_r <= '0;
            end
          end
          lfs_pkg::REG_IN_DRV:  in_drv_r  <= cfg_data[15:0];
          lfs_pkg::REG_IN_GAIN: in_gain_r <= cfg_data;
          lfs_pkg::REG_FB_DRV:  fb_drv_r  <= cfg_data[15:0];
          lfs_pkg::REG_FB_GAIN: fb_gain_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (wr_en && cnt_r == 3'd4) begin
        row_valid_r <= row_valid_r | (CHANNELS'(1) << ch_r);
      end
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_COEF;
      pass_r      <= 1'b0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RUN;
            step_r  <= SP_COEF;
            pass_r  <= 1'b0;
            cnt_r   <= 3'd0;
          end
        end
        ST_RUN: begin
          case (step_r)
            SP_DSG: begin
              if (!pass_r) begin
                pass_r <= 1'b1;
                step_r <= SP_DRV;
              end else begin
                step_r <= SP_FBD;
              end
            end
            SP_V0: begin
              cnt_r  <= 3'd1;
              step_r <= SP_MA;
            end
            SP_ACC: begin
              if (cnt_r == 3'd4) begin
                cnt_r  <= 3'd0;
                step_r <= SP_MIX;
              end else begin
                cnt_r  <= cnt_r + 3'd1;
                step_r <= SP_MA;
              end
            end
            SP_MIX: begin
              if (cnt_r == 3'd4) begin
                step_r <= SP_MIXE;
              end else begin
                cnt_r <= cnt_r + 3'd1;
              end
            end
            SP_FIN: begin
              state_r <= ST_DONE;
            end
            default: begin
              step_r <= step_r + 5'd1;
            end
          endcase
        end
        ST_DONE: begin
          // result waits here only while the output register is held
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= 56'(mul_a) * 56'(mul_b);
    if (in_acc) begin
      x_r     <= in_sample_in;
      ch_in_r <= in_channel;
      ch_r    <= (CHANNELS > 1) ? in_channel : 1'b0;
      a1_r    <= (in_cutoff_coef > lfs_pkg::ONE_Q16) ? lfs_pkg::ONE_Q16 : in_cutoff_coef;
      resl_r  <= (in_resonance_level > lfs_pkg::ONE_Q16) ? lfs_pkg::ONE_Q16
                                                           : in_resonance_level;
    end
    if (state_r == ST_RUN) begin
      case (step_r)
        SP_BCOEF: begin
          b0_r <= 17'(lfs_pkg::rnd_shift(64'(prod_r), 16));
          b1_r <= g - 17'(lfs_pkg::rnd_shift(64'(prod_r), 16));
        end
        SP_ARG: begin
          arg_r <= lfs_pkg::sat24(lfs_pkg::rnd_shift(64'(prod_r), 12));
        end
        SP_POS: begin
          neg_r <= arg_r[23];
        end
        SP_IDX: begin
          idx_r  <= prod_r[23 + IW - 1:23];
          frac_r <= prod_r[22:0];
          ovf_r  <= (prod_r[23 + IW - 1:23] >= IW'(SAT_TABLE_ENTRIES));
        end
        SP_LUT: begin
          // beyond the table the curve stays flat at its last point
          if (ovf_r) begin
            lo_r <= TANH_TAB[SAT_TABLE_ENTRIES];
            hi_r <= TANH_TAB[SAT_TABLE_ENTRIES];
          end else begin
            lo_r <= TANH_TAB[idx_r];
            hi_r <= TANH_TAB[idx_r + IW'(1)];
          end
        end
        SP_TNH: begin
          tanh_r <= neg_r ? -tanh_mag : tanh_mag;
        end
        SP_DSG: begin
          if (!pass_r) begin
            dx_r <= dsg_val;
          end else begin
            fb_r <= dsg_val;
          end
        end
        SP_V0: begin
          // ladder input: dx minus 4 * resonance * (fb - comp * dx)
          v_r[0] <= lfs_pkg::sat24(64'(dx_r)
                    - lfs_pkg::rnd_shift(64'(prod_r) <<< 2, 16));
        end
        SP_MB: begin
          acc_r <= 48'(prod_r);
        end
        SP_MC: begin
          acc_r <= stage_sum;
        end
        SP_ACC: begin
          v_r[cnt_r] <= lfs_pkg::sat24(lfs_pkg::rnd_shift(64'(stage_sum), 16));
        end
        SP_MIX: begin
          acc_r <= (cnt_r == 3'd0) ? 48'sd0 : stage_sum;
        end
        SP_MIXE: begin
          acc_r <= stage_sum;
        end
        SP_FIN: begin
          res_r <= lfs_pkg::sat24(lfs_pkg::rnd_shift(64'(prod_r), 16));
        end
        default: begin
        end
      endcase
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_sample_r <= res_r;
      out_ch_r     <= ch_in_r;
    end
  end

endmodule

`default_nettype wire

[bench/ladder_filter_step_top_test.sv]
// ladder_filter_step_top_test: self-checking bench for the ladder filter step.
// Random and directed sample transactions go through the block. A fixed-point
// filter predictor checks each output transaction. Depends on lfs_pkg and
// ladder_filter_step_top.
`timescale 1ns / 1ps

module ladder_filter_step_top_test;

  localparam int CH_COUNT   = 2;
  localparam int TAB_N      = 256;
  localparam int SETTLE_CYC = 60;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               chan;
    logic [16:0]        cutoff;
    logic [16:0]        reso;
  } sample_txn_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               chan;
  } filt_out_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] in_sample_in;
  logic in_channel;
  logic [16:0] in_cutoff_coef;
  logic [16:0] in_resonance_level;
  logic out_valid;
  logic out_stall;
  logic signed [23:0] out_sample_out;
  logic out_channel_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [16:0] cfg_data;

  ladder_filter_step_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_channel(in_channel),
    .in_cutoff_coef(in_cutoff_coef), .in_resonance_level(in_resonance_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_channel_out(out_channel_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model copy of the registers and the ladder memory
  logic [2:0]  m_mode;
  logic [15:0] m_in_drv;
  logic [16:0] m_in_gain;
  logic [15:0] m_fb_drv;
  logic [16:0] m_fb_gain;
  longint      ladder_mem [CH_COUNT][lfs_pkg::NSTAGE];
  longint      tanh_curve [TAB_N+1];

  // per-mode mixing weights and feedback compensation flag
  int weight_tab [6][lfs_pkg::NSTAGE] = '{
    '{0, 0, 1, 0, 0}, '{1, -2, 1, 0, 0}, '{0, 1, -1, 0, 0},
    '{0, 0, 0, 0, 1}, '{1, -4, 6, -4, 1}, '{0, 0, 1, -2, 1}
  };
  bit half_comp [6] = '{1, 0, 1, 1, 0, 1};

  sample_txn_t pending_samples[$];
  filt_out_t   expected_outs[$];
  bit          failed;
  longint      cycle_cnt;

  // round half up: add half, then arithmetic (floor) shift
  function automatic longint rnd(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // tanh curve in Q0.30, built by the addition formula from tanh(h)
  task automatic make_tanh_curve();
    longint h, h2, p, t, den, num, cur;
    h  = ((longint'(8) <<< 30) + TAB_N / 2) / TAB_N;
    h2 = rnd(h * h, 30);
    p  = h;
    t  = h;
    p = rnd(p * h2, 30); t -= p / 3;
    p = rnd(p * h2, 30); t += (p * 2) / 15;
    p = rnd(p * h2, 30); t -= (p * 17) / 315;
    p = rnd(p * h2, 30); t += (p * 62) / 2835;
    tanh_curve[0] = 0;
    for (int k = 0; k < TAB_N; k++) begin
      cur = tanh_curve[k];
      den = (longint'(1) <<< 30) + rnd(cur * t, 30);
      num = (cur + t) <<< 30;
      tanh_curve[k+1] = (num + den / 2) / den;
    end
  endtask

  function automatic longint tanh_q30(longint x);
    longint mag, pos, idx, frac, r;
    mag  = (x < 0) ? -x : x;
    pos  = mag * TAB_N;
    idx  = pos >>> 23;
    frac = pos & ((longint'(1) <<< 23) - 1);
    if (idx >= TAB_N) begin
      r = tanh_curve[TAB_N];
    end else begin
      r = tanh_curve[idx] + (((tanh_curve[idx+1] - tanh_curve[idx]) * frac) >>> 23);
    end
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint shape(longint x, longint drv, longint gain);
    longint arg;
    arg = clip24(rnd(drv * x, 12));
    return clip24(rnd(gain * tanh_q30(arg), 26));
  endfunction

  // one filter step on the model state
  function automatic filt_out_t filter_step(sample_txn_t s);
    filt_out_t r;
    longint a1, res, g, b0, b1, dx, fb, dxc, acc;
    longint v [lfs_pkg::NSTAGE];
    int ch, md;
    ch  = s.chan;
    md  = (m_mode <= lfs_pkg::MODE_BPF24) ? m_mode : 0;
    a1  = (s.cutoff > lfs_pkg::ONE_Q16) ? 65536 : s.cutoff;
    res = (s.reso > lfs_pkg::ONE_Q16) ? 65536 : s.reso;
    g   = 65536 - a1;
    b0  = rnd(g * 50412, 16);
    b1  = g - b0;
    dx  = shape(longint'(s.sample), m_in_drv, m_in_gain);
    fb  = shape(ladder_mem[ch][4], m_fb_drv, m_fb_gain);
    dxc = half_comp[md] ? rnd(dx, 1) : 0;
    v[0] = clip24(dx - rnd(4 * res * (fb - dxc), 16));
    for (int i = 1; i < lfs_pkg::NSTAGE; i++)
      v[i] = clip24(rnd(b1 * ladder_mem[ch][i-1] + a1 * ladder_mem[ch][i]
                        + b0 * v[i-1], 16));
    acc = 0;
    for (int i = 0; i < lfs_pkg::NSTAGE; i++) begin
      ladder_mem[ch][i] = v[i];
      acc += weight_tab[md][i] * v[i];
    end
    r.sample = 24'(clip24(rnd(acc * 78643, 16)));
    r.chan   = s.chan;
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [16:0] d);
    case (idx)
      lfs_pkg::REG_MODE: begin
        // invalid codes ignored; a new valid mode wipes the ladder
        if (d[2:0] <= lfs_pkg::MODE_BPF24 && d[2:0] != m_mode) begin
          m_mode = d[2:0];
          foreach (ladder_mem[c, i]) ladder_mem[c][i] = 0;
        end
      end
      lfs_pkg::REG_IN_DRV:  m_in_drv  = d[15:0];
      lfs_pkg::REG_IN_GAIN: m_in_gain = d;
      lfs_pkg::REG_FB_DRV:  m_fb_drv  = d[15:0];
      lfs_pkg::REG_FB_GAIN: m_fb_gain = d;
      default: ;
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // prediction: every accepted input and config transaction updates the model
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        expected_outs.push_back(filter_step(
          '{sample: in_sample_in, chan: in_channel,
            cutoff: in_cutoff_coef, reso: in_resonance_level}));
    end
  end

  // sender: bursts of random length with random gaps between them
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    sample_txn_t nx;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 4;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall)) begin
      // previous transaction taken, or nothing presented
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() > 0) begin
        nx = pending_samples.pop_front();
        in_valid           <= 1'b1;
        in_sample_in       <= nx.sample;
        in_channel         <= nx.chan;
        in_cutoff_coef     <= nx.cutoff;
        in_resonance_level <= nx.reso;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          // some gaps long enough to land on any sequencer step
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: runs of stall / no stall, with quiet stretches
  int stall_run;
  int quiet_run;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
      quiet_run <= 0;
    end else if (quiet_run > 0) begin
      out_stall <= 1'b0;
      quiet_run <= quiet_run - 1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          out_stall <= 1'b0;
          quiet_run <= $urandom_range(100, 400);
        end
        1, 2: begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(1, 80);
        end
        default: begin
          out_stall <= 1'b0;
          stall_run <= $urandom_range(1, 30);
        end
      endcase
    end
  end

  // checker: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected output transaction sample=%0d chan=%0d",
                 $time, out_sample_out, out_channel_out);
        failed = 1'b1;
      end else begin
        want = expected_outs.pop_front();
        if (want.sample !== out_sample_out) begin
          $display("%0t: sample_out mismatch expected %0d actual %0d",
                   $time, want.sample, out_sample_out);
          failed = 1'b1;
        end
        if (want.chan !== out_channel_out) begin
          $display("%0t: channel_out mismatch expected %0d actual %0d",
                   $time, want.chan, out_channel_out);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [2:0] md, logic [15:0] idrv, logic [16:0] igain,
                          logic [15:0] fdrv, logic [16:0] fgain);
    write_reg(lfs_pkg::REG_MODE, {14'd0, md});
    write_reg(lfs_pkg::REG_IN_DRV, {1'b0, idrv});
    write_reg(lfs_pkg::REG_IN_GAIN, igain);
    write_reg(lfs_pkg::REG_FB_DRV, {1'b0, fdrv});
    write_reg(lfs_pkg::REG_FB_GAIN, fgain);
  endtask

  // wait until every transaction has come out, then let the sequencer settle
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_outs.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic add_sample(int smp, bit ch, int cut, int rs);
    pending_samples.push_back('{sample: 24'(smp), chan: ch,
                                cutoff: 17'(cut), reso: 17'(rs)});
  endtask

  // mostly musical values, sometimes anything the fields can hold
  task automatic add_random(int n);
    int smp, cut, rs;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) smp = int'($urandom_range(0, 24'hFFFFFF));
      else smp = int'($urandom_range(0, 2 * 1048576)) - 1048576;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                        : $urandom_range(0, 65536);
      rs  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                        : $urandom_range(0, 65536);
      add_sample(smp, $urandom_range(0, 1), cut, rs);
    end
  endtask

  initial begin
    failed    = 1'b0;
    cycle_cnt = 0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lfs_pkg::REG_MODE;
    cfg_data  = '0;
    in_sample_in       = '0;
    in_channel         = 1'b0;
    in_cutoff_coef     = '0;
    in_resonance_level = '0;
    m_mode    = lfs_pkg::MODE_LPF12;
    m_in_drv  = 16'd4915;
    m_in_gain = 17'd50286;
    m_fb_drv  = 16'd4129;
    m_fb_gain = 17'd64742;
    foreach (ladder_mem[c, i]) ladder_mem[c][i] = 0;
    make_tanh_curve();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, field extremes, coefficients above one
    add_sample(8388607, 0, 0, 0);
    add_sample(-8388608, 0, 0, 0);
    add_sample(0, 1, 65536, 65536);
    add_sample(8388607, 1, 65536, 65536);
    add_sample(-8388608, 1, 131071, 131071);
    add_sample(8388607, 0, 131071, 65537);
    add_sample(-1, 0, 32768, 65536);
    add_sample(1, 1, 1, 1);
    add_sample(4194304, 0, 65535, 65535);
    add_sample(-4194304, 1, 16384, 98304);
    add_sample(8388607, 0, 0, 65536);
    add_sample(8388607, 0, 0, 65536);
    add_sample(-8388608, 0, 0, 65536);
    add_sample(1048576, 1, 70000, 0);
    drain();

    // each mode with extreme drives and gains, including out-of-range ones
    set_regs(lfs_pkg::MODE_HPF12, 16'd4096, 17'd65536, 16'd4096, 17'd0);
    add_sample(8388607, 0, 0, 65536);
    add_sample(-8388608, 1, 65536, 0);
    add_random(120);
    drain();
    set_regs(lfs_pkg::MODE_BPF12, 16'd65535, 17'd0, 16'd65535, 17'd65536);
    add_random(120);
    drain();
    set_regs(lfs_pkg::MODE_LPF24, 16'd65535, 17'd65536, 16'd65535, 17'd65536);
    add_sample(8388607, 1, 0, 65536);
    add_random(120);
    drain();
    // invalid mode codes and unused indexes must leave everything alone
    set_regs(lfs_pkg::MODE_HPF24, 16'd4096, 17'd131071, 16'd0, 17'd131071);
    write_reg(lfs_pkg::REG_MODE, 17'd7);
    write_reg(lfs_pkg::REG_MODE, 17'h1FFFE);
    write_reg(3'd5, 17'h1FFFF);
    write_reg(3'd6, 17'd0);
    write_reg(3'd7, 17'h15555);
    add_random(120);
    drain();
    set_regs(lfs_pkg::MODE_BPF24, 16'hFFFF, 17'd50286, 16'd4129, 17'd64742);
    add_random(60);
    drain();
    // rewriting the same mode keeps the ladder state
    write_reg(lfs_pkg::REG_MODE, {14'd0, lfs_pkg::MODE_BPF24});
    add_random(60);
    drain();
    set_regs(lfs_pkg::MODE_LPF12, 16'd4915, 17'd50286, 16'd4129, 17'd64742);
    add_random(120);
    drain();

    // random settings within and around the ranges
    repeat (4) begin
      set_regs(3'($urandom_range(0, 5)), 16'($urandom_range(4096, 65535)),
               17'($urandom_range(0, 65536)), 16'($urandom_range(4096, 65535)),
               17'($urandom_range(0, 65536)));
      add_random(100);
      drain();
    end
    set_regs(lfs_pkg::MODE_LPF24, 16'($urandom_range(0, 65535)),
             17'($urandom_range(0, 131071)),
             16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
    add_random(60);
    drain();

    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[ladder_filter_step_top.f]
hdl/lfs_pkg.sv
hdl/ladder_filter_step_top.sv
bench/ladder_filter_step_top_test.sv
